FILE: src/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and constants of the websocket frame deframer
// frame header codes, result kinds and the token that passes front to back
// ----------------------------------------------------------------------------
package wsd_pkg;

  // token queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // frame header codes
  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_EXT64   = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] OPC_CLOSE   = 4'd8;

  // message field characters
  localparam logic [7:0] CHR_BAR   = 8'h7C;
  localparam logic [7:0] ENC_BYTES = 8'h31;
  localparam logic [7:0] ENC_WORDS = 8'h32;

  typedef enum logic [2:0] {
    KIND_ENC     = 3'd0,
    KIND_OPC     = 3'd1,
    KIND_ID      = 3'd2,
    KIND_DATA    = 3'd3,
    KIND_END     = 3'd4,
    KIND_CLOSE   = 3'd5,
    KIND_INVALID = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    HP_FIRST   = 3'd0,
    HP_LEN     = 3'd1,
    HP_EXTLEN  = 3'd2,
    HP_MASK    = 3'd3,
    HP_PAYLOAD = 3'd4
  } hdr_phase_t;

  typedef enum logic [1:0] {
    SEC_ENC  = 2'd0,
    SEC_OPC  = 2'd1,
    SEC_ID   = 2'd2,
    SEC_DATA = 2'd3
  } msg_section_t;

  // one classified event from the frame parser
  typedef struct packed {
    logic        has_byte;
    logic [7:0]  byte_val;
    logic        end_msg;
    logic        is_close;
    logic [15:0] close_code;
  } tok_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] value;
  } result_t;

endpackage

FILE: src/wsd_in_if.sv
// ----------------------------------------------------------------------------
// wsd_in_if: received byte channel
// valid/ready stream carrying one byte of the websocket stream per beat
// ----------------------------------------------------------------------------
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: src/wsd_out_if.sv
// ----------------------------------------------------------------------------
// wsd_out_if: result channel
// valid/ready stream carrying one result kind and value per beat
// ----------------------------------------------------------------------------
interface wsd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [15:0] result_value;

  modport source (output valid, output result_kind, output result_value, input ready);
  modport sink (input valid, input result_kind, input result_value, output ready);
endinterface

FILE: src/websocket_frame_deframer.sv
// path: the token of an accepted byte is queued, then loaded into the registered
//   result stage, which drives the result beat
// throughput: one byte per cycle while the token queue has room; a byte giving
//   two results holds the back end for both beats, which the four-entry queue absorbs
// the single result register and a full token queue set the stall points
// reset: synchronous active-low rst_n returns the parser to the first header byte
// ----------------------------------------------------------------------------
// websocket_frame_deframer: client-to-server websocket frame deframer
// parses frame headers, unmasks payloads, joins continuation frames and
// splits each message into encoding, opcode, id and data results
// ----------------------------------------------------------------------------
module websocket_frame_deframer import wsd_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  wsd_in_if.sink          in_bus,
  wsd_out_if.source       out_bus
);

  logic tok_valid;
  tok_t tok;
  logic q_ready;
  logic q_valid;
  tok_t q_tok;
  logic q_pop;
  logic pair_pending;

  // header parser and unmasker
  wsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .rx_byte   (in_bus.rx_byte),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_ready (q_ready)
  );

  // token queue
  wsd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (tok_valid),
    .push_ready (q_ready),
    .push_tok   (tok),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_tok    (q_tok)
  );

  // message splitter and result stage
  wsd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .tok_valid    (q_valid),
    .tok          (q_tok),
    .tok_pop      (q_pop),
    .out_valid    (out_bus.valid),
    .out_ready    (out_bus.ready),
    .result_kind  (out_bus.result_kind),
    .result_value (out_bus.result_value),
    .pair_pending (pair_pending)
  );

`ifndef NO_ASSERTIONS
  // a token with a second result still due stays at the queue head
  a_pair_has_token: assert property (@(posedge clk) disable iff (!rst_n)
    pair_pending |-> q_valid)
    else $error("second result pending with empty token queue");

  // the first of two results is on the channel when the pair opens
  a_pair_first_shown: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(pair_pending) |-> out_bus.valid)
    else $error("pair opened without a result beat");

  // after reset the queue is empty and no result is offered
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> (in_bus.ready && !out_bus.valid && !pair_pending))
    else $error("state not cleared by reset");
`endif

endmodule

FILE: src/wsd_front.sv
// ----------------------------------------------------------------------------
// wsd_front: frame header parser and unmasker
// walks the frame header, unmasks payload bytes, gathers the close code and
// turns each byte into at most one token for the message back end
// ----------------------------------------------------------------------------
module wsd_front import wsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       tok_valid,
  output tok_t       tok,
  input  logic       tok_ready
);

  hdr_phase_t  phase_r, phase_nxt;
  logic        final_r, final_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic [3:0]  len_left_r, len_left_nxt;
  logic [63:0] payload_left_r, payload_left_nxt;
  logic [31:0] mask_key_r, mask_key_nxt;
  logic [1:0]  mask_pos_r, mask_pos_nxt;
  logic [15:0] close_acc_r, close_acc_nxt;
  logic [1:0]  close_taken_r, close_taken_nxt;

  logic       take;
  logic       frame_end;
  logic [7:0] key_byte;
  logic [7:0] unmasked;
  logic [6:0] len7;

  assign take     = in_valid && tok_ready;
  assign in_ready = tok_ready;
  assign len7     = rx_byte[6:0];

  // mask key byte for this payload position, first key byte at the top
  always_comb begin
    case (mask_pos_r)
      2'd0:    key_byte = mask_key_r[31:24];
      2'd1:    key_byte = mask_key_r[23:16];
      2'd2:    key_byte = mask_key_r[15:8];
      default: key_byte = mask_key_r[7:0];
    endcase
  end

  assign unmasked = rx_byte ^ key_byte;

  // header walk and payload handling
  always_comb begin
    phase_nxt        = phase_r;
    final_nxt        = final_r;
    opcode_nxt       = opcode_r;
    len_left_nxt     = len_left_r;
    payload_left_nxt = payload_left_r;
    mask_key_nxt     = mask_key_r;
    mask_pos_nxt     = mask_pos_r;
    close_acc_nxt    = close_acc_r;
    close_taken_nxt  = close_taken_r;
    frame_end        = 1'b0;
    tok              = '0;

    if (take) begin
      case (phase_r)
        HP_LEN: begin
          mask_pos_nxt = 2'd0;
          if (len7 == LEN_EXT16) begin
            payload_left_nxt = '0;
            len_left_nxt     = EXT16_BYTES;
            phase_nxt        = HP_EXTLEN;
          end else if (len7 == LEN_EXT64) begin
            payload_left_nxt = '0;
            len_left_nxt     = EXT64_BYTES;
            phase_nxt        = HP_EXTLEN;
          end else begin
            payload_left_nxt = {57'd0, len7};
            phase_nxt        = HP_MASK;
          end
        end
        HP_EXTLEN: begin
          payload_left_nxt = {payload_left_r[55:0], rx_byte};
          len_left_nxt     = len_left_r - 4'd1;
          if (len_left_nxt == 4'd0) begin
            phase_nxt = HP_MASK;
          end
        end
        HP_MASK: begin
          mask_key_nxt = {mask_key_r[23:0], rx_byte};
          mask_pos_nxt = mask_pos_r + 2'd1;
          if (mask_pos_nxt == 2'd0) begin
            if (payload_left_r == 64'd0) begin
              frame_end = 1'b1;
            end else begin
              phase_nxt = HP_PAYLOAD;
            end
          end
        end
        HP_PAYLOAD: begin
          mask_pos_nxt = mask_pos_r + 2'd1;
          if (opcode_r[3]) begin
            // control frame: only a close frame keeps its first two bytes
            if (opcode_r == OPC_CLOSE && close_taken_r < 2'd2) begin
              close_acc_nxt   = {close_acc_r[7:0], unmasked};
              close_taken_nxt = close_taken_r + 2'd1;
            end
          end else begin
            tok.has_byte = 1'b1;
            tok.byte_val = unmasked;
          end
          payload_left_nxt = payload_left_r - 64'd1;
          // last payload byte of the frame
          if (payload_left_r == 64'd1) begin
            frame_end = 1'b1;
          end
        end
        default: begin
          final_nxt  = rx_byte[7];
          opcode_nxt = rx_byte[3:0];
          if (rx_byte[3:0] == OPC_CLOSE) begin
            close_acc_nxt   = '0;
            close_taken_nxt = 2'd0;
          end
          phase_nxt = HP_LEN;
        end
      endcase

      // end of frame: close code or end of a final data frame
      if (frame_end) begin
        phase_nxt = HP_FIRST;
        if (opcode_r[3]) begin
          if (opcode_r == OPC_CLOSE) begin
            tok.is_close    = 1'b1;
            tok.close_code  = (close_taken_nxt >= 2'd2) ? close_acc_nxt : 16'd0;
            close_acc_nxt   = '0;
            close_taken_nxt = 2'd0;
          end
        end else if (final_r) begin
          tok.end_msg = 1'b1;
        end
      end
    end
  end

  assign tok_valid = take && (tok.has_byte || tok.end_msg || tok.is_close);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= HP_FIRST;
      final_r        <= 1'b0;
      opcode_r       <= '0;
      len_left_r     <= '0;
      payload_left_r <= '0;
      mask_key_r     <= '0;
      mask_pos_r     <= '0;
      close_acc_r    <= '0;
      close_taken_r  <= '0;
    end else begin
      phase_r        <= phase_nxt;
      final_r        <= final_nxt;
      opcode_r       <= opcode_nxt;
      len_left_r     <= len_left_nxt;
      payload_left_r <= payload_left_nxt;
      mask_key_r     <= mask_key_nxt;
      mask_pos_r     <= mask_pos_nxt;
      close_acc_r    <= close_acc_nxt;
      close_taken_r  <= close_taken_nxt;
    end
  end

endmodule

FILE: src/wsd_fifo.sv
// ----------------------------------------------------------------------------
// wsd_fifo: token queue
// short first-in first-out queue that lets parser and back end stall apart
// ----------------------------------------------------------------------------
module wsd_fifo import wsd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  tok_t push_tok,
  output logic pop_valid,
  input  logic pop_ready,
  output tok_t pop_tok
);

  tok_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;
  logic               push;
  logic               pop;

  assign push_ready = (count_r != (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_tok    = mem_r[rd_ptr_r];

  // pointer and level update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

FILE: src/wsd_back.sv
// ----------------------------------------------------------------------------
// wsd_back: message splitter and result stage
// splits the joined message into encoding, opcode, id and data fields and
// drives the registered result channel, two beats for a two-result token
// ----------------------------------------------------------------------------
module wsd_back import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        tok_valid,
  input  tok_t        tok,
  output logic        tok_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  result_kind,
  output logic [15:0] result_value,
  output logic        pair_pending
);

  msg_section_t section_r, section_nxt;
  logic [7:0]   enc_r, enc_nxt;
  logic         held_v_r, held_v_nxt;
  logic [7:0]   held_r, held_nxt;
  logic         pair_r, pair_nxt;
  logic         out_valid_r, out_valid_nxt;
  result_t      out_res_r, out_res_nxt;

  msg_section_t sec_mid;
  logic [7:0]   enc_mid;
  logic         held_v_mid;
  logic [7:0]   held_mid;
  logic [1:0]   res_cnt;
  result_t      res_a;
  result_t      res_b;
  logic         load_ok;
  logic         commit;
  logic         load;

  // results of the head token against the current message state
  always_comb begin
    sec_mid    = section_r;
    enc_mid    = enc_r;
    held_v_mid = held_v_r;
    held_mid   = held_r;
    res_cnt    = 2'd0;
    res_a      = '{kind: KIND_ENC, value: 16'd0};
    res_b      = '{kind: KIND_ENC, value: 16'd0};

    if (tok.has_byte) begin
      case (section_r)
        SEC_ENC: begin
          enc_mid = tok.byte_val;
          sec_mid = SEC_OPC;
          res_a   = '{kind: KIND_ENC, value: {8'd0, tok.byte_val}};
          res_cnt = 2'd1;
        end
        SEC_OPC: begin
          if (tok.byte_val == CHR_BAR) begin
            sec_mid = SEC_ID;
          end else begin
            res_a   = '{kind: KIND_OPC, value: {8'd0, tok.byte_val}};
            res_cnt = 2'd1;
          end
        end
        SEC_ID: begin
          if (tok.byte_val == CHR_BAR) begin
            sec_mid = SEC_DATA;
          end else begin
            res_a   = '{kind: KIND_ID, value: {8'd0, tok.byte_val}};
            res_cnt = 2'd1;
          end
        end
        default: begin
          if (enc_r == ENC_BYTES) begin
            res_a   = '{kind: KIND_DATA, value: {8'd0, tok.byte_val}};
            res_cnt = 2'd1;
          end else if (enc_r == ENC_WORDS) begin
            // big-endian 16-bit units: hold the high byte until its partner
            if (held_v_r) begin
              res_a      = '{kind: KIND_DATA, value: {held_r, tok.byte_val}};
              res_cnt    = 2'd1;
              held_v_mid = 1'b0;
              held_mid   = 8'd0;
            end else begin
              held_v_mid = 1'b1;
              held_mid   = tok.byte_val;
            end
          end
        end
      endcase
    end

    // close code of a close frame
    if (tok.is_close) begin
      if (res_cnt == 2'd0) begin
        res_a = '{kind: KIND_CLOSE, value: tok.close_code};
      end else begin
        res_b = '{kind: KIND_CLOSE, value: tok.close_code};
      end
      res_cnt = res_cnt + 2'd1;
    end

    // message end, or invalid when a field is left open
    if (tok.end_msg) begin
      if (res_cnt == 2'd0) begin
        res_a = '{kind: (sec_mid == SEC_DATA) ? KIND_END : KIND_INVALID, value: 16'd0};
      end else begin
        res_b = '{kind: (sec_mid == SEC_DATA) ? KIND_END : KIND_INVALID, value: 16'd0};
      end
      res_cnt    = res_cnt + 2'd1;
      sec_mid    = SEC_ENC;
      enc_mid    = 8'd0;
      held_v_mid = 1'b0;
      held_mid   = 8'd0;
    end
  end

  assign load_ok = !out_valid_r || out_ready;

  // token retire and result stage load
  always_comb begin
    commit      = 1'b0;
    load        = 1'b0;
    tok_pop     = 1'b0;
    pair_nxt    = pair_r;
    out_res_nxt = out_res_r;

    if (tok_valid) begin
      if (res_cnt == 2'd0) begin
        commit  = 1'b1;
        tok_pop = 1'b1;
      end else if (load_ok) begin
        load = 1'b1;
        if (res_cnt == 2'd1) begin
          out_res_nxt = res_a;
          commit      = 1'b1;
          tok_pop     = 1'b1;
        end else if (!pair_r) begin
          out_res_nxt = res_a;
          pair_nxt    = 1'b1;
        end else begin
          out_res_nxt = res_b;
          pair_nxt    = 1'b0;
          commit      = 1'b1;
          tok_pop     = 1'b1;
        end
      end
    end

    section_nxt = commit ? sec_mid : section_r;
    enc_nxt     = commit ? enc_mid : enc_r;
    held_v_nxt  = commit ? held_v_mid : held_v_r;
    held_nxt    = commit ? held_mid : held_r;

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      section_r   <= SEC_ENC;
      enc_r       <= '0;
      held_v_r    <= 1'b0;
      held_r      <= '0;
      pair_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      section_r   <= section_nxt;
      enc_r       <= enc_nxt;
      held_v_r    <= held_v_nxt;
      held_r      <= held_nxt;
      pair_r      <= pair_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid    = out_valid_r;
  assign result_kind  = 3'(out_res_r.kind);
  assign result_value = out_res_r.value;
  assign pair_pending = pair_r;

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the websocket frame deframer
// feeds masked client frames one byte per beat and checks every result beat
// against a cycle-free model of the parser; short directed frames come first,
// then random messages split over frames, control frames and noise
// ----------------------------------------------------------------------------
module tb_top import wsd_pkg::*; ();

  localparam int ITEM_TARGET = 1625;
  localparam int PAUSE_EVERY = 500;
  localparam int SHOW_LIMIT  = 10;
  localparam int DIRECTED_N  = 25;

  typedef struct {
    logic [7:0]  rx;
    logic        typed;
    kind_t       kind;
    logic [15:0] value;
  } stim_row_t;

  logic clk;
  logic rst_n;

  wsd_in_if  in_bus ();
  wsd_out_if out_bus ();

  websocket_frame_deframer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // parser model state
  hdr_phase_t   hdr_phase;
  logic         fin;
  logic [3:0]   opc;
  logic [3:0]   ext_left;
  logic [63:0]  pay_left;
  logic [31:0]  mkey;
  logic [1:0]   mpos;
  msg_section_t section;
  logic [7:0]   enc;
  logic [8:0]   held;
  logic [1:0]   close_taken;
  logic [15:0]  close_code;

  // results of the byte just modelled
  kind_t       step_kind [2];
  logic [15:0] step_val [2];
  int          step_cnt;

  result_t     due_results [$];
  result_t     head;
  logic [7:0]  msg_text [$];
  logic [7:0]  frame_body [$];
  stim_row_t   directed_rows [DIRECTED_N];
  int          fail_count;
  int          bytes_accepted;
  int          next_pause;
  logic        in_calm;
  logic        out_calm;

  function automatic void note_fail(input string msg);
    fail_count++;
    if (fail_count <= SHOW_LIMIT) $display("%s", msg);
  endfunction

  function automatic void deframer_reset();
    hdr_phase   = HP_FIRST;
    fin         = 1'b0;
    opc         = 4'h0;
    ext_left    = 4'h0;
    pay_left    = 64'd0;
    mkey        = 32'h0;
    mpos        = 2'd0;
    section     = SEC_ENC;
    enc         = 8'h00;
    held        = 9'h000;
    close_taken = 2'd0;
    close_code  = 16'h0000;
  endfunction

  function automatic void emit(input kind_t k, input logic [15:0] v);
    step_kind[step_cnt] = k;
    step_val[step_cnt]  = v;
    step_cnt++;
  endfunction

  // frame complete: close code, or message end / invalid on a final data frame
  function automatic void finish_frame();
    if (opc[3]) begin
      if (opc == OPC_CLOSE) begin
        emit(KIND_CLOSE, (close_taken >= 2'd2) ? close_code : 16'h0000);
        close_taken = 2'd0;
        close_code  = 16'h0000;
      end
    end else if (fin) begin
      emit((section == SEC_DATA) ? KIND_END : KIND_INVALID, 16'h0000);
      section = SEC_ENC;
      enc     = 8'h00;
      held    = 9'h000;
    end
    hdr_phase = HP_FIRST;
  endfunction

  // one unmasked byte of the joined message
  function automatic void message_byte(input logic [7:0] d);
    case (section)
      SEC_ENC: begin
        enc     = d;
        section = SEC_OPC;
        emit(KIND_ENC, {8'h00, d});
      end
      SEC_OPC: begin
        if (d == CHR_BAR) section = SEC_ID;
        else emit(KIND_OPC, {8'h00, d});
      end
      SEC_ID: begin
        if (d == CHR_BAR) section = SEC_DATA;
        else emit(KIND_ID, {8'h00, d});
      end
      default: begin
        if (enc == ENC_BYTES) begin
          emit(KIND_DATA, {8'h00, d});
        end else if (enc == ENC_WORDS) begin
          if (held[8]) begin
            emit(KIND_DATA, {held[7:0], d});
            held = 9'h000;
          end else begin
            held = {1'b1, d};
          end
        end
      end
    endcase
  endfunction

  function automatic void payload_byte(input logic [7:0] b);
    logic [7:0] d;
    d    = b ^ mkey[31 - 8 * int'(mpos) -: 8];
    mpos = mpos + 2'd1;
    if (opc[3]) begin
      // close payload feeds the code, other control payloads are dropped
      if (opc == OPC_CLOSE && close_taken < 2'd2) begin
        close_code  = {close_code[7:0], d};
        close_taken = close_taken + 2'd1;
      end
    end else begin
      message_byte(d);
    end
    pay_left = pay_left - 64'd1;
    if (pay_left == 64'd0) finish_frame();
  endfunction

  // model one accepted byte, filling step_kind / step_val
  function automatic void deframe_byte(input logic [7:0] b);
    step_cnt = 0;
    case (hdr_phase)
      HP_LEN: begin
        mpos     = 2'd0;
        pay_left = 64'd0;
        if (b[6:0] == LEN_EXT16) begin
          ext_left  = EXT16_BYTES;
          hdr_phase = HP_EXTLEN;
        end else if (b[6:0] == LEN_EXT64) begin
          ext_left  = EXT64_BYTES;
          hdr_phase = HP_EXTLEN;
        end else begin
          pay_left  = 64'(b[6:0]);
          hdr_phase = HP_MASK;
        end
      end
      HP_EXTLEN: begin
        pay_left = {pay_left[55:0], b};
        ext_left = ext_left - 4'd1;
        if (ext_left == 4'd0) hdr_phase = HP_MASK;
      end
      HP_MASK: begin
        mkey = {mkey[23:0], b};
        mpos = mpos + 2'd1;
        if (mpos == 2'd0) begin
          if (pay_left == 64'd0) finish_frame();
          else hdr_phase = HP_PAYLOAD;
        end
      end
      HP_PAYLOAD: payload_byte(b);
      default: begin
        fin = b[7];
        opc = b[3:0];
        if (opc == OPC_CLOSE) begin
          close_taken = 2'd0;
          close_code  = 16'h0000;
        end
        hdr_phase = HP_LEN;
      end
    endcase
  endfunction

  // noise that keeps any length it builds within one byte
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (hdr_phase == HP_EXTLEN && ext_left > 4'd1) b = 8'h00;
    return b;
  endfunction

  // drive one beat, then queue what it should produce
  task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                           input kind_t tk = KIND_ENC, input logic [15:0] tv = 16'h0000);
    int gap;
    gap = in_calm ? 0 : int'($urandom_range(0, 12));
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.rx_byte <= b;
    do @(posedge clk); while (!in_bus.ready);
    bytes_accepted++;
    deframe_byte(b);
    if (typed) begin
      due_results.insert(due_results.size(), result_t'{kind: tk, value: tv});
    end else begin
      for (int i = 0; i < step_cnt; i++)
        due_results.insert(due_results.size(),
                           result_t'{kind: step_kind[i], value: step_val[i]});
    end
  endtask

  task automatic hold_until_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  // one masked frame carrying frame_body
  task automatic send_frame(input logic fin_bit, input logic [3:0] opcode);
    logic [7:0] mk [4];
    logic       mbit;
    int         len;
    int         form;
    len  = frame_body.size();
    form = (len < 126 && $urandom_range(0, 4) != 0) ? 0 : int'($urandom_range(1, 2));
    mbit = ($urandom_range(0, 7) != 0);
    send_byte({fin_bit, 3'($urandom), opcode});
    case (form)
      0: send_byte({mbit, 7'(len)});
      1: begin
        send_byte({mbit, LEN_EXT16});
        send_byte(8'(len >> 8));
        send_byte(8'(len));
      end
      default: begin
        send_byte({mbit, LEN_EXT64});
        for (int k = 7; k >= 0; k--) send_byte(8'(64'(len) >> (8 * k)));
      end
    endcase
    for (int k = 0; k < 4; k++) mk[k] = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
    for (int k = 0; k < 4; k++) send_byte(mk[k]);
    for (int k = 0; k < len; k++) send_byte(frame_body[k] ^ mk[k % 4]);
  endtask

  // close, ping, pong or reserved control frame with a short payload
  task automatic send_control();
    int n;
    n = $urandom_range(0, 5);
    frame_body.delete();
    repeat (n) frame_body.insert(frame_body.size(), 8'($urandom));
    send_frame($urandom_range(0, 5) != 0, 4'($urandom_range(8, 15)));
  endtask

  // one message: encoding, opcode, id and data, split over up to three frames
  task automatic send_message();
    int         r;
    int         n;
    int         keep;
    int         nfrag;
    int         pos;
    int         hi;
    logic       lastf;
    logic [3:0] opcode;
    logic [7:0] c;
    msg_text.delete();
    r = $urandom_range(0, 4);
    msg_text.insert(msg_text.size(),
                    (r < 2) ? ENC_BYTES : (r < 4) ? ENC_WORDS : 8'($urandom));
    for (int s = 0; s < 2; s++) begin
      n = $urandom_range(0, 4);
      repeat (n) begin
        c = 8'($urandom);
        if (c == CHR_BAR) c = c ^ 8'h01;
        msg_text.insert(msg_text.size(), c);
      end
      msg_text.insert(msg_text.size(), CHR_BAR);
    end
    n = ($urandom_range(0, 19) == 0) ? int'($urandom_range(100, 300))
                                     : int'($urandom_range(0, 12));
    repeat (n) msg_text.insert(msg_text.size(), 8'($urandom));
    // cut short: any shorter prefix, down to an empty message
    if ($urandom_range(0, 7) == 0) begin
      keep = $urandom_range(0, msg_text.size() - 1);
      while (msg_text.size() > keep) void'(msg_text.pop_back());
    end
    nfrag = $urandom_range(1, 3);
    pos   = 0;
    for (int f = 0; f < nfrag; f++) begin
      lastf = (f == nfrag - 1);
      hi    = lastf ? msg_text.size() : int'($urandom_range(pos, msg_text.size()));
      if ($urandom_range(0, 4) == 0) send_control();
      frame_body.delete();
      for (int k = pos; k < hi; k++) frame_body.insert(frame_body.size(), msg_text[k]);
      if (f == 0)
        opcode = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 7))
                                             : 4'($urandom_range(1, 2));
      else
        opcode = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(1, 7)) : 4'h0;
      // now and then the message is left open and joins the next one
      send_frame(lastf && ($urandom_range(0, 9) != 0), opcode);
      pos = hi;
    end
  endtask

  // garbage bytes, then whatever frame they started is run to its end
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) send_byte(noise_byte());
    while (hdr_phase != HP_FIRST) send_byte(noise_byte());
  endtask

  // result side: random stalls, calm stretches
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = out_calm ? 0 : int'($urandom_range(0, 12));
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (due_results.size() == 0) begin
        note_fail($sformatf("unexpected result beat: kind %0d value %h",
                            out_bus.result_kind, out_bus.result_value));
      end else begin
        head = due_results.pop_front();
        if (out_bus.result_kind !== head.kind || out_bus.result_value !== head.value)
          note_fail($sformatf("mismatch: kind exp %0d got %0d, value exp %h got %h",
                              head.kind, out_bus.result_kind, head.value,
                              out_bus.result_value));
      end
    end
  end

  // hard stop
  initial begin
    #7_200_000;
    $display("status: fail");
    $finish;
  end

  // stimulus
  initial begin
    directed_rows = '{
      // close frame, empty payload: code reads as zero
      '{8'h88, 1'b0, KIND_ENC, 16'h0000}, '{8'h80, 1'b0, KIND_ENC, 16'h0000},
      '{8'h00, 1'b0, KIND_ENC, 16'h0000}, '{8'h00, 1'b0, KIND_ENC, 16'h0000},
      '{8'h00, 1'b0, KIND_ENC, 16'h0000}, '{8'h00, 1'b1, KIND_CLOSE, 16'h0000},
      // final text frame, mask bit clear, empty: message is invalid
      '{8'h81, 1'b0, KIND_ENC, 16'h0000}, '{8'h00, 1'b0, KIND_ENC, 16'h0000},
      '{8'hFF, 1'b0, KIND_ENC, 16'h0000}, '{8'hFF, 1'b0, KIND_ENC, 16'h0000},
      '{8'hFF, 1'b0, KIND_ENC, 16'h0000}, '{8'hFF, 1'b1, KIND_INVALID, 16'h0000},
      // reserved bits set, 16-bit length, word data ending with message end
      '{8'hF2, 1'b0, KIND_ENC, 16'h0000}, '{8'hFE, 1'b0, KIND_ENC, 16'h0000},
      '{8'h00, 1'b0, KIND_ENC, 16'h0000}, '{8'h05, 1'b0, KIND_ENC, 16'h0000},
      '{8'hFF, 1'b0, KIND_ENC, 16'h0000}, '{8'hFF, 1'b0, KIND_ENC, 16'h0000},
      '{8'hFF, 1'b0, KIND_ENC, 16'h0000}, '{8'hFF, 1'b0, KIND_ENC, 16'h0000},
      '{8'hCD, 1'b0, KIND_ENC, 16'h0000}, '{8'h83, 1'b0, KIND_ENC, 16'h0000},
      '{8'h83, 1'b0, KIND_ENC, 16'h0000}, '{8'h54, 1'b0, KIND_ENC, 16'h0000},
      '{8'h32, 1'b0, KIND_ENC, 16'h0000}
    };
    fail_count     = 0;
    bytes_accepted = 0;
    next_pause     = PAUSE_EVERY;
    in_calm        = 1'b0;
    out_calm       = 1'b0;
    deframer_reset();
    rst_n          <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.rx_byte <= 8'h00;
    out_bus.ready  <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames
    foreach (directed_rows[i])
      send_byte(directed_rows[i].rx, directed_rows[i].typed,
                directed_rows[i].kind, directed_rows[i].value);
    hold_until_drained();

    // random traffic, mostly well-formed messages
    while (bytes_accepted < ITEM_TARGET) begin
      case ($urandom_range(0, 19))
        16, 17:  send_control();
        18, 19:  send_noise();
        default: send_message();
      endcase
      if (bytes_accepted >= next_pause) begin
        hold_until_drained();
        next_pause += PAUSE_EVERY;
      end
    end

    // drain, then a short tail to catch stray beats
    hold_until_drained();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && due_results.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

FILE: sim.f
src/wsd_pkg.sv
src/wsd_in_if.sv
src/wsd_out_if.sv
src/wsd_front.sv
src/wsd_fifo.sv
src/wsd_back.sv
src/websocket_frame_deframer.sv
bench/tb_top.sv
